// ===== src/pwd_pkg.sv =====
`default_nettype none

package pwd_pkg;

  // number of pwm channels
  localparam int LED_COUNT = 4;

  // field and register widths
  localparam int PERIOD_W    = 8;
  localparam int DUTY_W      = 8;
  localparam int STEP_W      = 8;
  localparam int DEBOUNCE_W  = 16;
  localparam int BLINK_ON_W  = 4;
  localparam int BLINK_OFF_W = 12;
  localparam int ADJ_W       = 2;
  localparam int LEVELS_W    = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 3;

  // lit part of a blink cycle: blink_on_periods * period
  localparam int LIT_W   = BLINK_ON_W + PERIOD_W;
  // longest cycle is lit part plus dark part
  localparam int PHASE_W = LIT_W + 1;

  // reset values of the registers
  localparam logic [PERIOD_W-1:0]    RESET_PERIOD    = PERIOD_W'(100);
  localparam logic [STEP_W-1:0]      RESET_STEP      = STEP_W'(10);
  localparam logic [DEBOUNCE_W-1:0]  RESET_DEBOUNCE  = DEBOUNCE_W'(1700);
  localparam logic [BLINK_ON_W-1:0]  RESET_BLINK_ON  = BLINK_ON_W'(8);
  localparam logic [BLINK_OFF_W-1:0] RESET_BLINK_OFF = BLINK_OFF_W'(800);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PWM_PERIOD       = 3'd0,
    REG_DUTY_STEP        = 3'd1,
    REG_DEBOUNCE_TICKS   = 3'd2,
    REG_BLINK_ON_PERIODS = 3'd3,
    REG_BLINK_OFF_TICKS  = 3'd4
  } cfg_reg_t;

  // timing shared by all channels
  typedef struct packed {
    logic [PERIOD_W-1:0] period;     // period with zero taken as one
    logic [LIT_W-1:0]    lit_len;    // lit part of a blink cycle
    logic [PHASE_W-1:0]  blink_len;  // whole blink cycle
  } led_cfg_t;

endpackage

`default_nettype wire

// ===== src/four_led_pwm_dimmer_with_buttons.sv =====
// a result is registered in the cycle after its input transaction is accepted
// throughput: one transaction per cycle unless m_tready stalls; every tick updates debounce,
//   buttons and all four pwm channels in one pass, the result register decoupling the sides
// reset (rst, synchronous, active high): registers return to period 100, step 10,
//   debounce 1700, blink on 8, blink off 800; duties 10, led 0 adjusted, phases 0
`default_nettype none

module four_led_pwm_dimmer_with_buttons (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration write port
  input  wire logic                             cfg_write,
  input  wire logic [pwd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pwd_pkg::CFG_DATA_W-1:0]   cfg_data,
  // tick stream in
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [7:0]                       s_tdata,  // [0] button_event, [2:1] buttons_raw
  // level stream out
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [7:0]                            m_tdata   // [3:0] led_levels, [5:4] adjusted_led
);

  import pwd_pkg::*;

  // configuration registers
  logic [PERIOD_W-1:0]    pwm_period;
  logic [STEP_W-1:0]      duty_step;
  logic [DEBOUNCE_W-1:0]  debounce_ticks;
  logic [BLINK_ON_W-1:0]  blink_on_periods;
  logic [BLINK_OFF_W-1:0] blink_off_ticks;

  // button state
  logic [DEBOUNCE_W-1:0]  quiet_count;
  logic [ADJ_W-1:0]       adjust_index;
  logic [DUTY_W-1:0]      target_duty [LED_COUNT];

  logic                   accept;
  logic                   button_event;
  logic [1:0]             buttons_raw;
  logic [1:0]             held;
  logic                   press;
  logic [ADJ_W-1:0]       adjust_index_next;
  logic [DUTY_W-1:0]      target_duty_next [LED_COUNT];
  logic [STEP_W:0]        duty_sum;
  led_cfg_t               led_cfg;
  logic [LED_COUNT-1:0]   led_on;

  assign button_event = s_tdata[0];
  assign buttons_raw  = s_tdata[2:1];

  // a new tick is taken whenever the result register is free or being drained
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period       <= RESET_PERIOD;
      duty_step        <= RESET_STEP;
      debounce_ticks   <= RESET_DEBOUNCE;
      blink_on_periods <= RESET_BLINK_ON;
      blink_off_ticks  <= RESET_BLINK_OFF;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PWM_PERIOD:       pwm_period       <= cfg_data[PERIOD_W-1:0];
        REG_DUTY_STEP:        duty_step        <= cfg_data[STEP_W-1:0];
        REG_DEBOUNCE_TICKS:   debounce_ticks   <= cfg_data[DEBOUNCE_W-1:0];
        REG_BLINK_ON_PERIODS: blink_on_periods <= cfg_data[BLINK_ON_W-1:0];
        REG_BLINK_OFF_TICKS:  blink_off_ticks  <= cfg_data[BLINK_OFF_W-1:0];
        default: ;
      endcase
    end
  end

  // shared channel timing; a zero period counts as one tick
  always_comb begin
    led_cfg.period    = (pwm_period == '0) ? PERIOD_W'(1) : pwm_period;
    led_cfg.lit_len   = LIT_W'(blink_on_periods) * LIT_W'(led_cfg.period);
    led_cfg.blink_len = PHASE_W'(led_cfg.lit_len) + PHASE_W'(blink_off_ticks);
  end

  // debounced press: buttons are active low, exactly one must be held
  assign held     = ~buttons_raw;
  assign press    = button_event && (quiet_count > debounce_ticks);
  assign duty_sum = {1'b0, target_duty[adjust_index]} + {1'b0, duty_step};

  always_comb begin
    adjust_index_next = adjust_index;
    for (int i = 0; i < LED_COUNT; i++) begin
      target_duty_next[i] = target_duty[i];
    end
    if (press && held == 2'b01) begin
      // select alone steps to the next led
      adjust_index_next = (adjust_index == ADJ_W'(LED_COUNT - 1)) ? '0
                          : adjust_index + ADJ_W'(1);
    end else if (press && held == 2'b10) begin
      // adjust alone raises duty, back to dark once past the period
      target_duty_next[adjust_index] = (duty_sum > {1'b0, pwm_period}) ? '0
                                       : duty_sum[DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quiet_count  <= '0;
      adjust_index <= '0;
      for (int i = 0; i < LED_COUNT; i++) begin
        target_duty[i] <= RESET_STEP;
      end
    end else if (accept) begin
      // interrupt restarts the quiet count, otherwise it saturates
      if (button_event) begin
        quiet_count <= '0;
      end else if (quiet_count != '1) begin
        quiet_count <= quiet_count + DEBOUNCE_W'(1);
      end
      adjust_index <= adjust_index_next;
      target_duty  <= target_duty_next;
    end
  end

  // one pwm channel per led, all stepping on the same tick
  for (genvar g = 0; g < LED_COUNT; g++) begin : g_led
    pwd_led u_led (
      .clk         (clk),
      .rst         (rst),
      .advance     (accept),
      .cfg         (led_cfg),
      .target_duty (target_duty_next[g]),
      .blink_sel   (adjust_index_next == ADJ_W'(g)),
      .blink_reset (g == 0),
      .level       (led_on[g])
    );
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {2'b00, adjust_index_next, LEVELS_W'(led_on)};
    end
  end

  // each accepted tick leaves a result waiting
  a_result_after_accept : assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("no result after accepted transaction");

  // button state moves only on an accepted tick
  a_adjust_idle : assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(adjust_index) && $stable(quiet_count))
    else $error("button state changed without a transaction");

  // an interrupt clears the quiet count
  a_quiet_cleared : assert property (@(posedge clk) disable iff (rst)
    accept && button_event |=> quiet_count == '0)
    else $error("quiet count not cleared by interrupt");

  // reported index matches the register
  a_index_reported : assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tdata[5:4] == adjust_index)
    else $error("reported led index differs from adjust index");

endmodule

`default_nettype wire

// ===== src/pwd_led.sv =====
`default_nettype none

module pwd_led (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         advance,
  input  wire pwd_pkg::led_cfg_t            cfg,
  input  wire logic [pwd_pkg::DUTY_W-1:0]   target_duty,
  input  wire logic                         blink_sel,
  input  wire logic                         blink_reset,
  output logic                              level
);

  import pwd_pkg::*;

  logic [PHASE_W-1:0] phase;
  logic [DUTY_W-1:0]  active_duty;
  logic               active_blink;

  logic [DUTY_W-1:0]  lat_duty;
  logic               lat_blink;
  logic [PHASE_W-1:0] cycle_len;
  logic [PHASE_W:0]   phase_inc;
  logic [PHASE_W-1:0] phase_next;
  logic [PHASE_W-1:0] rem;

  // latch new duty and mode at the start of the cycle
  assign lat_duty  = (phase == '0) ? target_duty : active_duty;
  assign lat_blink = (phase == '0) ? blink_sel : active_blink;

  assign cycle_len  = lat_blink ? cfg.blink_len : PHASE_W'(cfg.period);
  assign phase_inc  = {1'b0, phase} + (PHASE_W+1)'(1);
  assign phase_next = (phase_inc >= {1'b0, cycle_len}) ? '0 : phase_inc[PHASE_W-1:0];

  // phase mod period; quotient fits in the blink-on width inside the lit part
  always_comb begin
    logic [PHASE_W-1:0] sub;
    rem = phase;
    for (int k = BLINK_ON_W - 1; k >= 0; k--) begin
      sub = PHASE_W'(cfg.period) << k;
      if (rem >= sub) begin
        rem = rem - sub;
      end
    end
  end

  always_comb begin
    if (lat_blink) begin
      level = (phase < PHASE_W'(cfg.lit_len)) && (rem < PHASE_W'(lat_duty));
    end else begin
      level = (phase < PHASE_W'(lat_duty));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= '0;
      active_duty  <= RESET_STEP;
      active_blink <= blink_reset;
    end else if (advance) begin
      phase        <= phase_next;
      active_duty  <= lat_duty;
      active_blink <= lat_blink;
    end
  end

endmodule

`default_nettype wire
